[sv/lru_k_page_translator_assert.svh]
// Assertion macros for the LRU-K page translator.
// Used by lru_k_page_translator.sv; expects clk and rst_n in scope.
`ifndef LRU_K_PAGE_TRANSLATOR_ASSERT_SVH
`define LRU_K_PAGE_TRANSLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LKPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LKPT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKPT_ASSERT(name, prop, msg)
`define LKPT_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[sv/lkpt_pkg.sv]
// Shared types and constants of the LRU-K page translator.
// No dependencies; used by the channel interface and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lkpt_pkg;
  localparam int ADDR_W        = 20;
  localparam int PHYS_W        = 16;
  localparam int PS_W          = 13;
  localparam int OFF_W         = 12;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAMES_CFG_W  = 5;
  localparam int DEPTH_CFG_W   = 3;
  localparam int PAGE_SIZE_MAX = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_DEPTH = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] virtual_address;
  } in_item_t;

  typedef struct packed {
    logic [PHYS_W-1:0] physical_address;
    logic              hit;
    logic              replaced;
    logic              out_of_range;
  } out_item_t;
endpackage
`default_nettype wire

[sv/lkpt_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
// Payload types come from lkpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lkpt_stream_if #(parameter type T = lkpt_pkg::in_item_t);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lru_k_page_translator.sv]
// Order of work: address division, then a page-table lookup and record on a hit or free frame;
// on an eviction, a scan with one owner/page/stamp read per frame in use comes before the record.
// One transaction at a time; the next is taken once the result sits in the output register.
// Reset: synchronous, active low; then a clearing pass over every entry of the page
// table, during which no transaction is accepted. Configuration returns to defaults.
`timescale 1ns / 1ps
`default_nettype none
module lru_k_page_translator #(
  parameter int PAGES       = 256,
  parameter int FRAMES      = 16,
  parameter int MAX_HISTORY = 4,
  parameter int STAMP_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lkpt_stream_if.sink                          in_ch,
  lkpt_stream_if.source                        out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lkpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lkpt_pkg::CFG_DATA_W-1:0] cfg_data
);
`include "lru_k_page_translator_assert.svh"

  localparam int PW  = $clog2(PAGES);
  localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW  = $clog2(FRAMES + 1);
  localparam int HW  = $clog2(MAX_HISTORY + 1);
  localparam int SW  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int SAW = $clog2(PAGES * MAX_HISTORY);
  localparam int DCW = $clog2(lkpt_pkg::ADDR_W);
  localparam int MW  = FW + lkpt_pkg::PS_W + 1;

  typedef struct packed {
    logic          res;
    logic [FW-1:0] frame;
    logic [HW-1:0] fill;
    logic [SW-1:0] oldest;
  } pte_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_CHK, S_LOOK, S_OWN, S_SPG, S_SST, S_CMP, S_VIC, S_REC, S_OUT
  } state_t;

  // configuration
  logic [lkpt_pkg::PS_W-1:0]         cfg_ps_r;
  logic [lkpt_pkg::FRAMES_CFG_W-1:0] cfg_fr_r;
  logic [lkpt_pkg::DEPTH_CFG_W-1:0]  cfg_hd_r;
  logic [lkpt_pkg::PS_W-1:0]         eff_ps;
  logic [NW-1:0]                     eff_n;
  logic [HW-1:0]                     eff_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ps_r <= lkpt_pkg::PS_W'(lkpt_pkg::PAGE_SIZE_MAX);
      cfg_fr_r <= lkpt_pkg::FRAMES_CFG_W'(16);
      cfg_hd_r <= lkpt_pkg::DEPTH_CFG_W'(2);
    end else if (cfg_we) begin
      case (cfg_idx)
        lkpt_pkg::CFG_PAGE_SIZE:     cfg_ps_r <= cfg_data;
        lkpt_pkg::CFG_FRAMES_IN_USE: cfg_fr_r <= cfg_data[lkpt_pkg::FRAMES_CFG_W-1:0];
        lkpt_pkg::CFG_HISTORY_DEPTH: cfg_hd_r <= cfg_data[lkpt_pkg::DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_ps_r == '0) eff_ps = lkpt_pkg::PS_W'(1);
    else if (cfg_ps_r > lkpt_pkg::PS_W'(lkpt_pkg::PAGE_SIZE_MAX))
      eff_ps = lkpt_pkg::PS_W'(lkpt_pkg::PAGE_SIZE_MAX);
    else eff_ps = cfg_ps_r;
    if (cfg_fr_r == '0) eff_n = NW'(1);
    else if (32'(cfg_fr_r) > FRAMES) eff_n = NW'(FRAMES);
    else eff_n = NW'(cfg_fr_r);
    if (cfg_hd_r == '0) eff_k = HW'(1);
    else if (32'(cfg_hd_r) > MAX_HISTORY) eff_k = HW'(MAX_HISTORY);
    else eff_k = HW'(cfg_hd_r);
  end

  function automatic logic [SW-1:0] mod_k(input logic [SW-1:0] v, input logic [HW-1:0] k);
    logic [HW:0] t;
    t = (HW+1)'(v);
    for (int j = 0; j < MAX_HISTORY; j++) begin
      if (t >= (HW+1)'(k)) t = t - (HW+1)'(k);
    end
    return t[SW-1:0];
  endfunction

  // slot holding the reference stamp of a page
  function automatic logic [SW-1:0] ref_slot(input pte_t w, input logic [HW-1:0] k);
    logic [HW-1:0] fm1;
    fm1 = w.fill - HW'(1);
    if (w.fill >= k) return mod_k(w.oldest, k);
    return fm1[SW-1:0];
  endfunction

  function automatic logic [SAW-1:0] st_addr(input logic [PW-1:0] pg, input logic [SW-1:0] s);
    return SAW'(pg) * SAW'(MAX_HISTORY) + SAW'(s);
  endfunction

  // memories
  pte_t                   pm [PAGES];
  logic [PW-1:0]          own_mem [FRAMES];
  logic [STAMP_WIDTH-1:0] st_mem [PAGES * MAX_HISTORY];

  logic [PW-1:0]          pm_ra;
  pte_t                   pm_rd_r;
  logic                   pm_we;
  logic [PW-1:0]          pm_wa;
  pte_t                   pm_wd;
  logic [PW-1:0]          own_rd_r;
  logic                   own_we;
  logic [SAW-1:0]         st_ra;
  logic [STAMP_WIDTH-1:0] st_rd_r;
  logic                   st_we;
  logic [SAW-1:0]         st_wa;

  // control and datapath registers
  state_t                     state_r;
  logic [PW-1:0]              clr_cnt_r;
  logic [lkpt_pkg::ADDR_W-1:0] quo_r;
  logic [lkpt_pkg::OFF_W-1:0] rem_r;
  logic [lkpt_pkg::PS_W-1:0]  ps_r;
  logic [DCW-1:0]             div_cnt_r;
  logic [PW-1:0]              pg_r;
  pte_t                       pg_word_r;
  logic [STAMP_WIDTH-1:0]     cnt_r;
  logic [FRAMES-1:0]          used_r;
  logic [FW-1:0]              frame_r;
  logic                       hit_r;
  logic                       repl_r;
  logic [FW-1:0]              scan_r;
  logic [PW-1:0]              cur_pg_r;
  pte_t                       cur_word_r;
  logic [STAMP_WIDTH-1:0]     best_r;
  logic [FW-1:0]              vic_frame_r;
  logic [PW-1:0]              vic_pg_r;
  pte_t                       vic_word_r;
  lkpt_pkg::out_item_t        res_r;
  lkpt_pkg::out_item_t        out_r;
  logic                       out_valid_r;

  // divider step
  logic [lkpt_pkg::OFF_W:0]   trial;
  logic                       trial_ge;
  // free frame search
  logic                       free_found;
  logic [FW-1:0]              free_idx;
  // record step
  logic                       rec_fill;
  logic [SW-1:0]              rec_slot;
  logic [SW:0]                slot_p1;
  pte_t                       rec_word;
  logic [MW-1:0]              phys_full;
  logic [STAMP_WIDTH-1:0]     age;
  logic                       scan_last;

  assign trial    = {rem_r, quo_r[lkpt_pkg::ADDR_W-1]};
  assign trial_ge = trial >= (lkpt_pkg::OFF_W+1)'(ps_r);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!free_found && (NW'(i) < eff_n) && !used_r[i]) begin
        free_found = 1'b1;
        free_idx   = FW'(i);
      end
    end
  end

  always_comb begin
    rec_fill = pg_word_r.fill < eff_k;
    rec_slot = rec_fill ? pg_word_r.fill[SW-1:0] : mod_k(pg_word_r.oldest, eff_k);
    slot_p1  = (SW+1)'(rec_slot) + (SW+1)'(1);
    rec_word = pg_word_r;
    rec_word.res   = 1'b1;
    rec_word.frame = frame_r;
    if (rec_fill) rec_word.fill = pg_word_r.fill + HW'(1);
    else rec_word.oldest = ((HW+1)'(slot_p1) == (HW+1)'(eff_k)) ? '0 : slot_p1[SW-1:0];
    phys_full = MW'(frame_r) * MW'(ps_r) + MW'(rem_r);
    age = cnt_r - ((cur_word_r.fill == '0) ? '0 : st_rd_r);
    scan_last = (NW'(scan_r) + NW'(1)) == eff_n;
  end

  // memory ports
  always_comb begin
    pm_ra = (state_r == S_SPG) ? own_rd_r : quo_r[PW-1:0];
    st_ra = st_addr(cur_pg_r, ref_slot(pm_rd_r, eff_k));
    pm_we = 1'b0;
    pm_wa = pg_r;
    pm_wd = rec_word;
    case (state_r)
      S_CLR: begin
        pm_we = 1'b1;
        pm_wa = clr_cnt_r;
        pm_wd = '0;
      end
      S_VIC: begin
        pm_we     = 1'b1;
        pm_wa     = vic_pg_r;
        pm_wd     = vic_word_r;
        pm_wd.res = 1'b0;
      end
      S_REC: pm_we = 1'b1;
      default: ;
    endcase
    own_we = (state_r == S_REC) && !hit_r;
    st_we  = (state_r == S_REC);
    st_wa  = st_addr(pg_r, rec_slot);
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm[pm_wa] <= pm_wd;
    pm_rd_r <= pm[pm_ra];
    if (own_we) own_mem[frame_r] <= pg_r;
    own_rd_r <= own_mem[scan_r];
    if (st_we) st_mem[st_wa] <= cnt_r;
    st_rd_r <= st_mem[st_ra];
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT decides the output valid itself
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + PW'(1);
          if (32'(clr_cnt_r) == PAGES - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            quo_r     <= in_ch.data.virtual_address;
            rem_r     <= '0;
            ps_r      <= eff_ps;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          quo_r <= {quo_r[lkpt_pkg::ADDR_W-2:0], trial_ge};
          rem_r <= trial_ge ? lkpt_pkg::OFF_W'(trial - (lkpt_pkg::OFF_W+1)'(ps_r))
                            : trial[lkpt_pkg::OFF_W-1:0];
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (32'(div_cnt_r) == lkpt_pkg::ADDR_W - 1) state_r <= S_CHK;
        end
        S_CHK: begin
          if (32'(quo_r) >= PAGES) begin
            res_r   <= '{physical_address: '0, hit: 1'b0, replaced: 1'b0, out_of_range: 1'b1};
            state_r <= S_OUT;
          end else begin
            pg_r     <= quo_r[PW-1:0];
            cnt_r    <= cnt_r + STAMP_WIDTH'(1);
            hit_r    <= 1'b0;
            repl_r   <= 1'b0;
            state_r  <= S_LOOK;
          end
        end
        S_LOOK: begin
          pg_word_r <= pm_rd_r;
          if (pm_rd_r.res) begin
            hit_r   <= 1'b1;
            frame_r <= pm_rd_r.frame;
            state_r <= S_REC;
          end else if (free_found) begin
            frame_r <= free_idx;
            state_r <= S_REC;
          end else begin
            scan_r  <= '0;
            state_r <= S_OWN;
          end
        end
        S_OWN: state_r <= S_SPG;
        S_SPG: begin
          cur_pg_r <= own_rd_r;
          state_r  <= S_SST;
        end
        S_SST: begin
          cur_word_r <= pm_rd_r;
          state_r    <= S_CMP;
        end
        S_CMP: begin
          // keep the first strictly greater age: ties stay on the lower frame
          if (scan_r == '0 || age > best_r) begin
            best_r      <= age;
            vic_frame_r <= scan_r;
            vic_pg_r    <= cur_pg_r;
            vic_word_r  <= cur_word_r;
          end
          if (scan_last) state_r <= S_VIC;
          else begin
            scan_r  <= scan_r + FW'(1);
            state_r <= S_OWN;
          end
        end
        S_VIC: begin
          frame_r <= vic_frame_r;
          repl_r  <= 1'b1;
          state_r <= S_REC;
        end
        S_REC: begin
          if (!hit_r) used_r[frame_r] <= 1'b1;
          res_r <= '{physical_address: phys_full[lkpt_pkg::PHYS_W-1:0], hit: hit_r,
                     replaced: repl_r, out_of_range: 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LKPT_ASSERT(a_oor_clean, out_ch.valid && out_ch.data.out_of_range |-> out_ch.data.physical_address == '0 && !out_ch.data.hit && !out_ch.data.replaced, "out of range result carries data")
  `LKPT_ASSERT(a_hit_no_evict, out_ch.valid |-> !(out_ch.data.hit && out_ch.data.replaced), "hit with eviction")
  `LKPT_ASSERT(a_victim_in_use, state_r == S_VIC |-> (NW'(vic_frame_r) < eff_n) && used_r[vic_frame_r], "victim frame outside usable range")
  `LKPT_ASSERT(a_cnt_step, state_r == S_LOOK |-> cnt_r == $past(cnt_r) + STAMP_WIDTH'(1), "access counter did not advance")
endmodule
`default_nettype wire

[verif/lkpt_tb_chan_if.sv]
// Testbench-side note: the channel interface lives with the RTL (lkpt_stream_if).
// This file holds a small package of testbench constants; it has no dependencies.
`timescale 1ns / 1ps
package lkpt_tb_pkg;
  localparam int TB_PAGES       = 256;
  localparam int TB_FRAMES      = 16;
  localparam int TB_MAX_HISTORY = 4;
  localparam int MAX_CYCLES     = 4000000;
endpackage

[verif/tb_lru_k_page_translator.sv]
// Self-checking testbench of the LRU-K page translator: directed table, then random
// address streams checked against a behavioral translator. Depends on lkpt_pkg,
// lkpt_stream_if and lkpt_tb_pkg.
`timescale 1ns / 1ps
module tb_lru_k_page_translator;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lkpt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [lkpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lkpt_stream_if #(.T(lkpt_pkg::in_item_t))  in_ch ();
  lkpt_stream_if #(.T(lkpt_pkg::out_item_t)) out_ch ();

  lru_k_page_translator u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Translator state mirror
  int unsigned ps_reg, frames_reg, depth_reg;
  bit          pg_res[lkpt_tb_pkg::TB_PAGES];
  int unsigned pg_frame[lkpt_tb_pkg::TB_PAGES];
  bit          fr_used[lkpt_tb_pkg::TB_FRAMES];
  int unsigned fr_owner[lkpt_tb_pkg::TB_FRAMES];
  bit [31:0]   stamps[lkpt_tb_pkg::TB_PAGES][lkpt_tb_pkg::TB_MAX_HISTORY];
  int unsigned fill[lkpt_tb_pkg::TB_PAGES];
  int unsigned oldest[lkpt_tb_pkg::TB_PAGES];
  bit [31:0]   access_cnt;

  lkpt_pkg::out_item_t pending_xlat[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic int unsigned eff_ps();
    if (ps_reg == 0) return 1;
    return (ps_reg > lkpt_pkg::PAGE_SIZE_MAX) ? lkpt_pkg::PAGE_SIZE_MAX : ps_reg;
  endfunction

  function automatic int unsigned eff_frames();
    if (frames_reg == 0) return 1;
    return (frames_reg > lkpt_tb_pkg::TB_FRAMES) ? lkpt_tb_pkg::TB_FRAMES : frames_reg;
  endfunction

  function automatic int unsigned eff_depth();
    if (depth_reg == 0) return 1;
    return (depth_reg > lkpt_tb_pkg::TB_MAX_HISTORY) ? lkpt_tb_pkg::TB_MAX_HISTORY
                                                     : depth_reg;
  endfunction

  function automatic bit [31:0] page_age(int unsigned pg);
    int unsigned k;
    bit [31:0] ref_stamp;
    k = eff_depth();
    if (fill[pg] >= k) ref_stamp = stamps[pg][oldest[pg] % k];
    else if (fill[pg] == 0) ref_stamp = '0;
    else ref_stamp = stamps[pg][fill[pg] - 1];
    return access_cnt - ref_stamp;
  endfunction

  function automatic void clear_mirror();
    ps_reg = 4096; frames_reg = 16; depth_reg = 2; access_cnt = '0;
    for (int p = 0; p < lkpt_tb_pkg::TB_PAGES; p++) begin
      pg_res[p] = 0; pg_frame[p] = 0; fill[p] = 0; oldest[p] = 0;
      for (int s = 0; s < lkpt_tb_pkg::TB_MAX_HISTORY; s++) stamps[p][s] = '0;
    end
    for (int f = 0; f < lkpt_tb_pkg::TB_FRAMES; f++) begin
      fr_used[f] = 0; fr_owner[f] = 0;
    end
  endfunction

  function automatic lkpt_pkg::out_item_t translate(logic [lkpt_pkg::ADDR_W-1:0] va);
    lkpt_pkg::out_item_t r;
    int unsigned ps, pg, off, frame, n, k, slot, victim;
    bit found;
    bit [31:0] best, a;
    ps = eff_ps();
    pg = va / ps;
    off = va % ps;
    r = '0;
    if (pg >= lkpt_tb_pkg::TB_PAGES) begin
      r.out_of_range = 1'b1;
      return r;
    end
    access_cnt = access_cnt + 1;
    frame = 0;
    if (pg_res[pg]) begin
      r.hit = 1'b1;
      frame = pg_frame[pg];
    end else begin
      n = eff_frames();
      found = 0;
      for (int i = 0; i < n && !found; i++)
        if (!fr_used[i]) begin
          frame = i; found = 1;
        end
      if (!found) begin
        best = page_age(fr_owner[0]);
        frame = 0;
        for (int i = 1; i < n; i++) begin
          a = page_age(fr_owner[i]);
          if (a > best) begin
            best = a; frame = i;
          end
        end
        victim = fr_owner[frame];
        pg_res[victim] = 0;
        r.replaced = 1'b1;
      end
      fr_used[frame] = 1; fr_owner[frame] = pg;
      pg_res[pg] = 1; pg_frame[pg] = frame;
    end
    k = eff_depth();
    if (fill[pg] < k) begin
      stamps[pg][fill[pg]] = access_cnt;
      fill[pg]++;
    end else begin
      slot = oldest[pg] % k;
      stamps[pg][slot] = access_cnt;
      oldest[pg] = (slot + 1) % k;
    end
    r.physical_address = lkpt_pkg::PHYS_W'(frame * ps + off);
    return r;
  endfunction

  // Directed table; check_fixed rows carry a typed-in expectation
  typedef struct {
    logic [lkpt_pkg::ADDR_W-1:0] va;
    bit                          check_fixed;
    lkpt_pkg::out_item_t         fixed;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{20'h00000, 1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
    '{20'h00FFF, 1, '{16'h0FFF, 1'b1, 1'b0, 1'b0}},
    '{20'h01123, 1, '{16'h1123, 1'b0, 1'b0, 1'b0}},
    '{20'hFFFFF, 0, '0},
    '{20'h00001, 1, '{16'h0001, 1'b1, 1'b0, 1'b0}},
    '{20'h0FFFF, 0, '0},
    '{20'hAAAAA, 0, '0},
    '{20'h55555, 0, '0},
    '{20'h02000, 0, '0},
    '{20'h01FFF, 0, '0}
  };

  task automatic cfg_write(logic [lkpt_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= lkpt_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lkpt_pkg::CFG_PAGE_SIZE) ps_reg = val & 13'h1FFF;
    else if (idx == lkpt_pkg::CFG_FRAMES_IN_USE) frames_reg = val & 5'h1F;
    else if (idx == lkpt_pkg::CFG_HISTORY_DEPTH) depth_reg = val & 3'h7;
  endtask

  // Drive one transaction, with random idle cycles ahead of it outside calm stretches
  task automatic send_addr(logic [lkpt_pkg::ADDR_W-1:0] va, bit check_fixed,
                           lkpt_pkg::out_item_t fixed);
    lkpt_pkg::out_item_t p;
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= va;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = translate(va);
    if (check_fixed && p !== fixed)
      $display("%0t: table row for %h disagrees: expected %h, predicted %h",
               $time, va, fixed, p);
    pending_xlat.push_back(check_fixed ? fixed : p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Result side: random stalls, compare at each accepted transaction
  always @(posedge clk) begin
    lkpt_pkg::out_item_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_xlat.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.data);
        errors = errors + 1;
      end else begin
        exp_r = pending_xlat.pop_front();
        if (out_ch.data.physical_address !== exp_r.physical_address) begin
          $display("%0t: physical_address expected %h actual %h", $time,
                   exp_r.physical_address, out_ch.data.physical_address);
          errors = errors + 1;
        end
        if (out_ch.data.hit !== exp_r.hit) begin
          $display("%0t: hit expected %b actual %b", $time, exp_r.hit, out_ch.data.hit);
          errors = errors + 1;
        end
        if (out_ch.data.replaced !== exp_r.replaced) begin
          $display("%0t: replaced expected %b actual %b", $time,
                   exp_r.replaced, out_ch.data.replaced);
          errors = errors + 1;
        end
        if (out_ch.data.out_of_range !== exp_r.out_of_range) begin
          $display("%0t: out_of_range expected %b actual %b", $time,
                   exp_r.out_of_range, out_ch.data.out_of_range);
          errors = errors + 1;
        end
      end
    end
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    if (cycles >= lkpt_tb_pkg::MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Random address: mostly a small working set so hits and evictions mix
  function automatic logic [lkpt_pkg::ADDR_W-1:0] pick_addr(int unsigned hot);
    int unsigned ps, pg;
    ps = eff_ps();
    case ($urandom_range(9))
      0: return lkpt_pkg::ADDR_W'($urandom);
      1: return $urandom_range(1) ? 20'hFFFFF : 20'h00000;
      default: begin
        pg = $urandom_range(hot - 1);
        return lkpt_pkg::ADDR_W'(pg * ps + $urandom_range(ps - 1));
      end
    endcase
  endfunction

  typedef struct { int unsigned ps, fr, dep, hot, n; } phase_t;

  phase_t phases[] = '{
    '{4096, 16, 2, 24, 150},
    '{1, 1, 1, 4, 100},
    '{256, 4, 4, 10, 200},
    '{0, 0, 0, 3, 100},
    '{8191, 31, 7, 40, 150},
    '{4000, 16, 3, 20, 150},
    '{64, 8, 2, 14, 250},
    '{16, 3, 4, 6, 150},
    '{4095, 12, 1, 30, 150},
    '{1024, 16, 4, 40, 200}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    clear_mirror();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_addr(dir_rows[i].va, dir_rows[i].check_fixed, dir_rows[i].fixed);
    drain();
    // Tiny pages with one frame: every new page evicts
    cfg_write(lkpt_pkg::CFG_PAGE_SIZE, 1);
    cfg_write(lkpt_pkg::CFG_FRAMES_IN_USE, 1);
    cfg_write(lkpt_pkg::CFG_HISTORY_DEPTH, 4);
    for (int i = 0; i < 6; i++) send_addr(lkpt_pkg::ADDR_W'(i % 3), 0, '0);
    send_addr(20'd256, 1, '{16'h0000, 1'b0, 1'b0, 1'b1});
    drain();

    foreach (phases[p]) begin
      cfg_write(lkpt_pkg::CFG_PAGE_SIZE, phases[p].ps);
      cfg_write(lkpt_pkg::CFG_FRAMES_IN_USE, phases[p].fr);
      cfg_write(lkpt_pkg::CFG_HISTORY_DEPTH, phases[p].dep);
      for (int i = 0; i < phases[p].n; i++) begin
        calm = (i >= phases[p].n / 2) && (i < phases[p].n / 2 + 30);
        send_addr(pick_addr(phases[p].hot), 0, '0);
      end
      calm = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
